[design/seld_pkg.sv]
// Shared types and constants of the sync/escape/length deframer.
// No dependencies; every other file of the block but seld_ram refers to this package.
`timescale 1ns / 1ps

package seld_pkg;

	localparam int BYTE_W = 8;
	localparam int IDX_W  = 6;
	localparam int FB_W   = 7;
	localparam int LEN_W  = 16;

	localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFD;
	localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'hFC;
	localparam logic [BYTE_W-1:0] HIGH_BIT  = 8'h80;
	localparam logic [LEN_W-1:0]  CRC_BYTES = 16'd2;

	// Parser position within a frame.
	typedef enum logic [3:0] {
		PH_IDLE   = 4'b0001,
		PH_LEN_HI = 4'b0010,
		PH_LEN_LO = 4'b0100,
		PH_DATA   = 4'b1000
	} phase_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_RUN    = 2'b01,
		ST_REPLAY = 2'b10
	} ctrl_state_t;

	typedef struct packed {
		logic take;   // an input request is accepted this cycle
		logic issue;  // read the next stored byte
	} ctrl_cmd_t;

	typedef struct packed {
		logic complete;  // the offered item ends a frame
		logic more;      // stored bytes remain to be read
		logic s1_valid;  // read data waits in the RAM output register
		logic advance;   // the output pipeline moves this cycle
	} dp_status_t;

endpackage

[design/seld_if.sv]
// Channel interfaces of the deframer: byte input, frame output, configuration.
// Depends on seld_pkg for field widths.
`timescale 1ns / 1ps

interface seld_in_if;
	logic                        valid;
	logic                        ready;
	logic                        mode;
	logic [seld_pkg::BYTE_W-1:0] byte_in;

	modport source (output valid, output mode, output byte_in, input ready);
	modport sink (input valid, input mode, input byte_in, output ready);
endinterface

interface seld_out_if;
	logic                        valid;
	logic                        ready;
	logic [seld_pkg::BYTE_W-1:0] data_out;
	logic [seld_pkg::IDX_W-1:0]  byte_index;
	logic [seld_pkg::FB_W-1:0]   frame_bytes;
	logic                        last;

	modport source (output valid, output data_out, output byte_index, output frame_bytes,
		output last, input ready);
	modport sink (input valid, input data_out, input byte_index, input frame_bytes,
		input last, output ready);
endinterface

interface seld_cfg_if;
	logic valid;
	logic ready;
	logic decode_escaped;

	modport source (output valid, output decode_escaped, input ready);
	modport sink (input valid, input decode_escaped, output ready);
endinterface

[design/sync_escape_length_deframer_top.sv]
// Top level of the sync/escape/length-prefixed frame deframer.
// Depends on seld_pkg, seld_if, seld_ctrl, seld_dp (and through it seld_ram).
//
// Usage:
//   bytes  - input requests: mode 0 delivers byte_in to the parser, mode 1 flushes the
//            parser and drops any partial frame. A request is taken when valid and ready
//            are both high at a rising clock edge.
//   frames - output requests: one per stored byte of a finished frame, with its position
//            (byte_index), the frame length (frame_bytes) and last on the final byte.
//   cfg    - writes decode_escaped; ready is always high. Write only while the block is
//            idle.
// Timing: a request that does not end a frame leaves ready high, so bytes are accepted
// back to back. A request that ends a frame (its length reached, or the store full)
// starts a replay out of the frame store RAM: each byte passes the RAM output register,
// then the output register, one byte per cycle while frames.ready stays high. The single
// RAM read port sets that rate. Input ready stays low from the ending request until the
// last byte has been read and moved to the output register. A stall on frames freezes
// the read pipeline and extends the replay.
// Reset clears the parser, the controller and the output valid; the frame store is not
// cleared, since a frame only replays bytes written after its own sync byte.

`timescale 1ns / 1ps

module sync_escape_length_deframer_top #(
	parameter int BUFFER_BYTES = 64
) (
	input logic        clk,
	input logic        arst_n,
	seld_in_if.sink    bytes,
	seld_out_if.source frames,
	seld_cfg_if.sink   cfg
);

	seld_pkg::ctrl_cmd_t  cmd;
	seld_pkg::dp_status_t sts;
	logic                 in_ready;

	// The controller owns the input handshake and the replay sequencing.
	seld_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(bytes.valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	assign bytes.ready = in_ready;

	// The datapath holds the parser registers, the frame store and the output stage.
	seld_dp #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.mode   (bytes.mode),
		.byte_in(bytes.byte_in),
		.cfg    (cfg),
		.frames (frames),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule

[design/seld_ram.sv]
// Generic single-write, single-read RAM with a registered, enabled read port.
// No dependencies.
`timescale 1ns / 1ps

module seld_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[design/seld_ctrl.sv]
// Controller of the deframer: alternates between taking input bytes and replaying a frame.
// Depends on seld_pkg for the state, command and status types.
`timescale 1ns / 1ps

module seld_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  seld_pkg::dp_status_t sts,
	output seld_pkg::ctrl_cmd_t  cmd
);

	seld_pkg::ctrl_state_t state_q, state_d;

	assign in_ready  = (state_q == seld_pkg::ST_RUN);
	assign cmd.take  = in_valid && in_ready;
	assign cmd.issue = (state_q == seld_pkg::ST_REPLAY) && sts.more && sts.advance;

	always_comb begin
		state_d = state_q;
		case (state_q)
			seld_pkg::ST_RUN: begin
				if (cmd.take && sts.complete) begin
					state_d = seld_pkg::ST_REPLAY;
				end
			end
			seld_pkg::ST_REPLAY: begin
				// Every byte read and the last one moved to the output register.
				if (!sts.more && !sts.s1_valid) begin
					state_d = seld_pkg::ST_RUN;
				end
			end
			default: state_d = seld_pkg::ST_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= seld_pkg::ST_RUN;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[design/seld_dp.sv]
// Datapath of the deframer: byte parser, frame store, replay read pipeline, output register.
// Depends on seld_pkg, seld_if and seld_ram.
`timescale 1ns / 1ps

module seld_dp #(
	parameter int BUFFER_BYTES = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        mode,
	input  logic [seld_pkg::BYTE_W-1:0] byte_in,
	seld_cfg_if.sink                    cfg,
	seld_out_if.source                  frames,
	input  seld_pkg::ctrl_cmd_t         cmd,
	output seld_pkg::dp_status_t        sts
);

	localparam int AW = $clog2(BUFFER_BYTES);
	localparam int CW = $clog2(BUFFER_BYTES + 1);

	logic                        decode_q;
	seld_pkg::phase_t            phase_q;
	logic                        esc_q;
	logic [seld_pkg::LEN_W-1:0]  exp_q;
	logic [seld_pkg::LEN_W-1:0]  dc_q;
	logic [CW-1:0]               fill_q;
	logic [CW-1:0]               n_q;
	logic [CW-1:0]               rd_cnt_q;
	logic [AW-1:0]               idx_s1;
	logic                        valid_s1;
	logic                        out_valid_q;
	logic [seld_pkg::BYTE_W-1:0] ram_rdata;

	logic                        is_sync, is_esc, is_plain, in_idle;
	logic [seld_pkg::BYTE_W-1:0] byte_dec, len_b, wdata;
	logic [seld_pkg::LEN_W-1:0]  dc_inc;
	logic [CW-1:0]               fill_new;
	logic                        store, data_done, complete, advance;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decode_q <= 1'b0;
		end else if (cfg.valid) begin
			decode_q <= cfg.decode_escaped;
		end
	end

	// Parser decode of the offered byte.
	assign is_sync  = (byte_in == seld_pkg::SYNC_BYTE);
	assign is_esc   = (byte_in == seld_pkg::ESC_BYTE);
	assign is_plain = !is_sync && !is_esc;
	assign in_idle  = (phase_q == seld_pkg::PH_IDLE);
	assign byte_dec = (esc_q && decode_q) ? (byte_in | seld_pkg::HIGH_BIT) : byte_in;
	assign len_b    = esc_q ? (byte_in | seld_pkg::HIGH_BIT) : byte_in;
	assign dc_inc   = dc_q + seld_pkg::LEN_W'(1);

	assign store = !mode && (is_sync || (!in_idle && (is_plain || (is_esc && !decode_q))));
	assign wdata = is_sync ? seld_pkg::SYNC_BYTE : (is_esc ? seld_pkg::ESC_BYTE : byte_dec);
	assign fill_new  = is_sync ? CW'(1) : fill_q + CW'(1);
	assign data_done = (phase_q == seld_pkg::PH_DATA) && is_plain && (dc_inc == exp_q);
	assign complete  = !mode && (data_done || (store && fill_new == CW'(BUFFER_BYTES)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= seld_pkg::PH_IDLE;
			esc_q   <= 1'b0;
			exp_q   <= '0;
			dc_q    <= '0;
			fill_q  <= '0;
			n_q     <= '0;
		end else if (cmd.take) begin
			if (mode) begin
				phase_q <= seld_pkg::PH_IDLE;
				fill_q  <= '0;
				esc_q   <= 1'b0;
			end else begin
				if (is_sync) begin
					esc_q   <= 1'b0;
					phase_q <= seld_pkg::PH_LEN_HI;
				end else if (is_esc) begin
					esc_q <= 1'b1;
				end else if (!in_idle) begin
					esc_q <= 1'b0;
					case (phase_q)
						seld_pkg::PH_LEN_HI: begin
							exp_q   <= {len_b, 8'h00};
							phase_q <= seld_pkg::PH_LEN_LO;
						end
						seld_pkg::PH_LEN_LO: begin
							exp_q   <= {exp_q[15:8], len_b} + seld_pkg::CRC_BYTES;
							dc_q    <= '0;
							phase_q <= seld_pkg::PH_DATA;
						end
						seld_pkg::PH_DATA: begin
							dc_q <= dc_inc;
						end
						default: phase_q <= seld_pkg::PH_IDLE;
					endcase
				end
				if (store) begin
					fill_q <= fill_new;
				end
				if (complete) begin
					phase_q <= seld_pkg::PH_IDLE;
					n_q     <= fill_new;
				end
			end
		end
	end

	seld_ram #(
		.WIDTH(seld_pkg::BYTE_W),
		.DEPTH(BUFFER_BYTES)
	) u_store (
		.clk  (clk),
		.we   (cmd.take && store),
		.waddr(is_sync ? AW'(0) : fill_q[AW-1:0]),
		.wdata(wdata),
		.re   (cmd.issue),
		.raddr(rd_cnt_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	// Replay: RAM output register is stage one, the output register stage two.
	assign advance = !out_valid_q || frames.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q    <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.take && complete) begin
				rd_cnt_q <= '0;
			end else if (cmd.issue) begin
				rd_cnt_q <= rd_cnt_q + CW'(1);
			end
			if (advance) begin
				valid_s1    <= cmd.issue;
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			idx_s1 <= rd_cnt_q[AW-1:0];
		end
		if (advance && valid_s1) begin
			frames.data_out    <= ram_rdata;
			frames.byte_index  <= seld_pkg::IDX_W'(idx_s1);
			frames.frame_bytes <= seld_pkg::FB_W'(n_q);
			frames.last        <= (CW'(idx_s1) + CW'(1) == n_q);
		end
	end

	assign frames.valid = out_valid_q;

	assign sts.complete = complete;
	assign sts.more     = (rd_cnt_q != n_q);
	assign sts.s1_valid = valid_s1;
	assign sts.advance  = advance;

endmodule

[design/seld_checker.sv]
// Port-level checks of the deframer and the bind that attaches them to the top level.
// Depends on seld_pkg and on sync_escape_length_deframer_top.
`timescale 1ns / 1ps

module seld_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [seld_pkg::BYTE_W-1:0] data_out,
	input logic [seld_pkg::IDX_W-1:0]  byte_index,
	input logic [seld_pkg::FB_W-1:0]   frame_bytes,
	input logic                        last
);

	// No input is taken while a frame is still being replayed.
	a_no_input_mid_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("input ready during frame replay");

	// A stalled output request holds its payload.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data_out) && $stable(byte_index)
			&& $stable(last))
		else $error("output changed under stall");

	// Within a run the next byte follows at once with the next index and the same length.
	a_run_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid
			&& byte_index == $past(byte_index) + seld_pkg::IDX_W'(1)
			&& frame_bytes == $past(frame_bytes))
		else $error("frame run broken");

	// last marks exactly the byte at position frame_bytes - 1.
	a_last_position: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> last == ({1'b0, byte_index} + seld_pkg::FB_W'(1) == frame_bytes))
		else $error("last flag misplaced");

endmodule

bind sync_escape_length_deframer_top seld_checker u_seld_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (bytes.ready),
	.out_valid  (frames.valid),
	.out_ready  (frames.ready),
	.data_out   (frames.data_out),
	.byte_index (frames.byte_index),
	.frame_bytes(frames.frame_bytes),
	.last       (frames.last)
);

[verif/sync_escape_length_deframer_top_test.sv]
// Self-checking testbench of the sync/escape/length-prefixed frame deframer.
// Depends on seld_pkg, the seld_if channel interfaces and sync_escape_length_deframer_top.
`timescale 1ns / 1ps

module sync_escape_length_deframer_top_test;

	localparam int STORE_DEPTH    = 64;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int CFG_SETTLE     = 8;   // cycles after the last frame byte before a write
	localparam int END_SETTLE     = 70;  // drain padding that covers the longest replay
	localparam int PHASE_REQUESTS = 16;  // counted requests per random phase

	// One replayed byte as the block should present it on the frame channel.
	typedef struct packed {
		logic [seld_pkg::BYTE_W-1:0] data;
		logic [seld_pkg::IDX_W-1:0]  index;
		logic [seld_pkg::FB_W-1:0]   total;
		logic                        last;
	} frame_byte_t;

	logic clk = 1'b0;
	logic arst_n;

	seld_in_if  bytes_ch();
	seld_out_if frames_ch();
	seld_cfg_if cfg_ch();

	sync_escape_length_deframer_top #(
		.BUFFER_BYTES(STORE_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.bytes(bytes_ch),
		.frames(frames_ch),
		.cfg(cfg_ch)
	);

	// 20 ns clock period.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Shadow copy of the parser. It is advanced once per accepted input request and
	// fills expected_bytes whenever a frame is completed or the store runs full.
	logic                        dec_en    = 1'b0;
	seld_pkg::phase_t            fr_phase  = seld_pkg::PH_IDLE;
	logic                        esc_pend  = 1'b0;
	logic [seld_pkg::LEN_W-1:0]  want_len  = '0;
	logic [seld_pkg::LEN_W-1:0]  data_cnt  = '0;
	int                          fill      = 0;
	logic [seld_pkg::BYTE_W-1:0] frame_buf [STORE_DEPTH];

	frame_byte_t expected_bytes[$];

	// When set, neither side inserts gaps, so the block sees back-to-back traffic.
	logic no_stall = 1'b0;

	int requests_sent = 0;
	int ignored_sent  = 0;
	int cfg_writes    = 0;
	int bytes_checked = 0;
	int frames_seen   = 0;
	int mismatches    = 0;
	int quiet_cycles  = 0;

	function automatic void keep_byte(input logic [seld_pkg::BYTE_W-1:0] value);
		if (fill < STORE_DEPTH) begin
			frame_buf[fill] = value;
			fill++;
		end
	endfunction

	// Works out what one accepted request does to the parser, and queues the frame
	// bytes that it releases.
	function automatic void model_request(input logic flush,
			input logic [seld_pkg::BYTE_W-1:0] value);
		logic [seld_pkg::BYTE_W-1:0] b;
		logic [seld_pkg::BYTE_W-1:0] len_b;
		logic                        done;
		frame_byte_t                 fb;
		b    = value;
		done = 1'b0;
		if (flush) begin
			fr_phase = seld_pkg::PH_IDLE;
			fill     = 0;
			esc_pend = 1'b0;
			return;
		end
		if (b == seld_pkg::SYNC_BYTE) begin
			// A sync byte always restarts the frame, even in the middle of one.
			fill     = 0;
			esc_pend = 1'b0;
			fr_phase = seld_pkg::PH_LEN_HI;
			keep_byte(b);
		end else if (b == seld_pkg::ESC_BYTE) begin
			// With decoding off, the escape byte is stored only inside a frame, and it
			// never counts toward the data length.
			esc_pend = 1'b1;
			if (dec_en || fr_phase == seld_pkg::PH_IDLE)
				return;
			keep_byte(b);
		end else begin
			if (esc_pend && dec_en)
				b = b | seld_pkg::HIGH_BIT;
			// Length bytes take the escape whatever the decode setting is.
			len_b = esc_pend ? (b | seld_pkg::HIGH_BIT) : b;
			case (fr_phase)
				seld_pkg::PH_LEN_HI: begin
					want_len = {len_b, 8'h00};
					fr_phase = seld_pkg::PH_LEN_LO;
				end
				seld_pkg::PH_LEN_LO: begin
					want_len = (want_len | {8'h00, len_b}) + seld_pkg::CRC_BYTES;
					data_cnt = '0;
					fr_phase = seld_pkg::PH_DATA;
				end
				seld_pkg::PH_DATA: begin
					data_cnt = data_cnt + 1'b1;
					if (data_cnt == want_len)
						done = 1'b1;
				end
				default: return;  // stray bytes while idle keep the pending escape
			endcase
			esc_pend = 1'b0;
			keep_byte(b);
		end
		if (fill >= STORE_DEPTH)
			done = 1'b1;
		if (done) begin
			for (int k = 0; k < fill; k++) begin
				fb.data  = frame_buf[k];
				fb.index = k[seld_pkg::IDX_W-1:0];
				fb.total = fill[seld_pkg::FB_W-1:0];
				fb.last  = (k == fill - 1);
				expected_bytes.push_back(fb);
			end
			fr_phase = seld_pkg::PH_IDLE;
		end
	endfunction

	function automatic logic [seld_pkg::BYTE_W-1:0] random_plain();
		logic [seld_pkg::BYTE_W-1:0] v;
		v = 8'($urandom_range(0, 255));
		if (v == seld_pkg::SYNC_BYTE || v == seld_pkg::ESC_BYTE)
			v = 8'($urandom_range(0, 8'hFB));
		return v;
	endfunction

	// Sends one input request after a random gap and updates the shadow parser on
	// the edge that accepts it. Valid stays high on return; whoever pauses lowers it.
	task automatic push_request(input logic flush, input logic [seld_pkg::BYTE_W-1:0] value);
		int gap;
		gap = no_stall ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			bytes_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		bytes_ch.valid   <= 1'b1;
		bytes_ch.mode    <= flush;
		bytes_ch.byte_in <= value;
		@(posedge clk);
		while (!bytes_ch.ready)
			@(posedge clk);
		model_request(flush, value);
		requests_sent++;
	endtask

	task automatic send_byte(input logic [seld_pkg::BYTE_W-1:0] value);
		push_request(1'b0, value);
	endtask

	// The byte field is don't-care on a flush, so it carries random bits.
	task automatic send_flush();
		push_request(1'b1, 8'($urandom_range(0, 255)));
	endtask

	// Stops sending and waits until every expected frame byte has come out, then
	// pads with idle cycles so the block can settle.
	task automatic settle_idle(input int pad);
		bytes_ch.valid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (pad) @(posedge clk);
	endtask

	// Configuration writes are only issued while the block is idle.
	task automatic write_decode(input logic enable);
		settle_idle(CFG_SETTLE);
		cfg_ch.valid          <= 1'b1;
		cfg_ch.decode_escaped <= enable;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		dec_en = enable;
		cfg_writes++;
	endtask

	// Directed: idle handling, a zero-length frame, a plain escape inside a frame,
	// a flushed partial frame and a sync that restarts a frame.
	task automatic test_idle_and_basic();
		write_decode(1'b0);
		// Bytes while idle are ignored; a plain escape while idle is not stored.
		send_byte(8'h00); send_byte(8'hFF); send_byte(seld_pkg::ESC_BYTE); send_byte(8'h41);
		// Zero length still carries the two CRC bytes.
		send_byte(seld_pkg::SYNC_BYTE); send_byte(8'h00); send_byte(8'h00);
		send_byte(8'hAA); send_byte(8'h55);
		// The stored escape does not count; the byte after it keeps bit 7 clear.
		send_byte(seld_pkg::SYNC_BYTE); send_byte(8'h00); send_byte(8'h01);
		send_byte(seld_pkg::ESC_BYTE); send_byte(8'h7F); send_byte(8'h12); send_byte(8'h34);
		// A flush drops the partial frame without output.
		send_byte(seld_pkg::SYNC_BYTE); send_byte(8'h00); send_byte(8'h05); send_byte(8'h11);
		send_flush();
		// A sync inside a frame restarts it.
		send_byte(seld_pkg::SYNC_BYTE); send_byte(8'h00); send_byte(8'h03); send_byte(8'h22);
		send_byte(seld_pkg::SYNC_BYTE); send_byte(8'h00); send_byte(8'h00);
		send_byte(8'h80); send_byte(8'h01);
	endtask

	// Decoding on: escapes are dropped, also while idle, and the next frame byte gets bit 7.
	task automatic test_escape_decode();
		write_decode(1'b1);
		send_byte(seld_pkg::ESC_BYTE); send_byte(8'h10);
		send_byte(seld_pkg::SYNC_BYTE); send_byte(8'h00); send_byte(8'h02);
		send_byte(seld_pkg::ESC_BYTE); send_byte(8'h05);
		send_byte(seld_pkg::ESC_BYTE); send_byte(8'h7F);
		send_byte(8'h33); send_byte(8'h44);
	endtask

	// Frames whose length cannot be reached end when the store is full: an escaped
	// length byte with decoding off, and a length that wraps to zero with decoding on.
	task automatic test_store_full();
		write_decode(1'b0);
		send_byte(seld_pkg::SYNC_BYTE); send_byte(seld_pkg::ESC_BYTE);
		send_byte(8'h00); send_byte(8'h00);
		repeat (STORE_DEPTH - 4) send_byte(random_plain());
		write_decode(1'b1);
		send_byte(seld_pkg::SYNC_BYTE); send_byte(8'hFF); send_byte(8'hFE);
		repeat (STORE_DEPTH - 3) send_byte(random_plain());
	endtask

	// A well-formed frame with random content; most are short, a few overflow the store.
	task automatic send_random_frame();
		logic [seld_pkg::BYTE_W-1:0] lo;
		lo = ($urandom_range(0, 11) == 0) ? 8'($urandom_range(60, 90))
			: 8'($urandom_range(0, 14));
		send_byte(seld_pkg::SYNC_BYTE);
		send_byte(8'h00);
		send_byte(lo);
		for (int n = 0; n < lo + 2; n++) begin
			if ($urandom_range(0, 9) == 0)
				send_byte(seld_pkg::ESC_BYTE);
			send_byte(random_plain());
		end
	endtask

	// A frame that may break off: random length bytes, a little data, then a flush or
	// a fresh sync.
	task automatic send_broken_frame();
		int n;
		send_byte(seld_pkg::SYNC_BYTE);
		send_byte(8'($urandom_range(0, 255)));
		send_byte(8'($urandom_range(0, 255)));
		n = $urandom_range(0, 3);
		repeat (n) send_byte(8'($urandom_range(0, 255)));
		if ($urandom_range(0, 1) == 0)
			send_flush();
		else
			send_byte(seld_pkg::SYNC_BYTE);
	endtask

	// Random traffic in phases with the decode setting alternating between them.
	task automatic test_random_traffic();
		int start;
		int pick;
		for (int ph = 0; ph < 4; ph++) begin
			write_decode(ph[0] ? 1'b0 : 1'b1);
			start = requests_sent - ignored_sent;
			while (requests_sent - ignored_sent - start < PHASE_REQUESTS) begin
				if ($urandom_range(0, 5) == 0)
					no_stall = ~no_stall;
				pick = $urandom_range(0, 9);
				if (pick == 0) begin
					send_flush();
				end else if (pick == 1) begin
					send_byte(8'($urandom_range(0, 255)));
					ignored_sent++;
				end else if (pick == 2) begin
					send_broken_frame();
				end else begin
					send_random_frame();
				end
			end
		end
		no_stall = 1'b0;
	endtask

	// Frame sink: takes each output request after a random stall and checks it
	// field by field against the oldest expected byte.
	initial begin : frame_sink
		int          stall;
		frame_byte_t got;
		frame_byte_t want;
		frames_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_stall ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				frames_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			frames_ch.ready <= 1'b1;
			@(posedge clk);
			while (!frames_ch.valid)
				@(posedge clk);
			got.data  = frames_ch.data_out;
			got.index = frames_ch.byte_index;
			got.total = frames_ch.frame_bytes;
			got.last  = frames_ch.last;
			if (got.last === 1'b1)
				frames_seen++;
			if (expected_bytes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected frame byte data=%h index=%0d total=%0d last=%b",
						$realtime, got.data, got.index, got.total, got.last);
			end else begin
				want = expected_bytes.pop_front();
				bytes_checked++;
				if (got.data !== want.data || got.index !== want.index
						|| got.total !== want.total || got.last !== want.last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$write("%0t: frame byte differs: expected data=%h index=%0d ",
							$realtime, want.data, want.index);
						$display("total=%0d last=%b, got data=%h index=%0d total=%0d last=%b",
							want.total, want.last, got.data, got.index, got.total, got.last);
					end
				end
			end
		end
	end

	// Watchdog: the run ends if no channel moves a request for too long.
	always @(posedge clk) begin
		if ((bytes_ch.valid && bytes_ch.ready) || (frames_ch.valid && frames_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired after %0d idle cycles", quiet_cycles);
			$display("sync_escape_length_deframer_top: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Main sequence: one reset, the directed tests, random traffic, then drain.
	initial begin
		arst_n                <= 1'b0;
		bytes_ch.valid        <= 1'b0;
		bytes_ch.mode         <= 1'b0;
		bytes_ch.byte_in      <= '0;
		cfg_ch.valid          <= 1'b0;
		cfg_ch.decode_escaped <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_and_basic();
		test_escape_decode();
		test_store_full();
		test_random_traffic();

		settle_idle(END_SETTLE);
		$display("Sent %0d input requests (%0d idle noise) over %0d decode writes.",
			requests_sent, ignored_sent, cfg_writes);
		$display("Checked %0d frame bytes in %0d frames; %0d mismatches, %0d still expected.",
			bytes_checked, frames_seen, mismatches, expected_bytes.size());
		if (mismatches == 0 && expected_bytes.size() == 0)
			$display("sync_escape_length_deframer_top: match");
		else
			$display("sync_escape_length_deframer_top: mismatch");
		$finish;
	end

endmodule
